@@ sv/tlms_pkg.sv @@
// Shared types, constants and a helper function for the redeem script matcher.
package tlms_pkg;

    localparam int KEY_BYTES        = 33;
    localparam int MAX_HEIGHT_BYTES = 4;
    localparam int KEY_ADDR_W       = $clog2(KEY_BYTES);
    localparam int HLEN_W           = $clog2(MAX_HEIGHT_BYTES + 1);
    localparam int HEIGHT_W         = 32;
    localparam int LOCK_W           = 29;
    localparam int QUEUE_DEPTH      = 2;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    localparam logic [HEIGHT_W-1:0] HEIGHT_LIMIT = 32'd500000000;

    localparam logic [7:0] OP_IF          = 8'h63;
    localparam logic [7:0] OP_CLTV        = 8'hb1;
    localparam logic [7:0] OP_DROP        = 8'h75;
    localparam logic [7:0] OP_PUSH33      = 8'h21;
    localparam logic [7:0] OP_CHECKSIG    = 8'hac;
    localparam logic [7:0] OP_ELSE        = 8'h67;
    localparam logic [7:0] OP_TWO         = 8'h52;
    localparam logic [7:0] OP_CHECKMULTI  = 8'hae;
    localparam logic [7:0] OP_BRANCH_END  = 8'h68;

    localparam logic [1:0] WHICH_NONE   = 2'd0;
    localparam logic [1:0] WHICH_FIRST  = 2'd1;
    localparam logic [1:0] WHICH_SECOND = 2'd2;

    localparam logic STATUS_ACCEPT = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    typedef enum logic [4:0] {
        S_IF,
        S_LEN,
        S_HEIGHT,
        S_CLTV,
        S_DROP,
        S_PUSH1,
        S_KEY1,
        S_CHECKSIG,
        S_ELSE,
        S_TWO1,
        S_PUSHA,
        S_KEY1_AGAIN,
        S_PUSHB,
        S_KEY2,
        S_TWO2,
        S_CMS,
        S_ENDIF,
        S_DONE
    } tlms_step_t;

    typedef struct packed {
        logic [7:0]        key_byte;
        logic [1:0]        key_which;
        logic [5:0]        key_index;
        logic              check_key;
        logic              key_mismatch;
        logic              finished;
        logic              front_ok;
        logic [LOCK_W-1:0] lock_height;
    } tlms_item_t;

    function automatic logic [7:0] want_op(input tlms_step_t step);
        logic [7:0] op;
        case (step)
            S_IF:       op = OP_IF;
            S_CLTV:     op = OP_CLTV;
            S_DROP:     op = OP_DROP;
            S_PUSH1:    op = OP_PUSH33;
            S_CHECKSIG: op = OP_CHECKSIG;
            S_ELSE:     op = OP_ELSE;
            S_TWO1:     op = OP_TWO;
            S_PUSHA:    op = OP_PUSH33;
            S_PUSHB:    op = OP_PUSH33;
            S_TWO2:     op = OP_TWO;
            S_CMS:      op = OP_CHECKMULTI;
            S_ENDIF:    op = OP_BRANCH_END;
            default:    op = 8'h00;
        endcase
        return op;
    endfunction

endpackage

@@ sv/tlms_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module tlms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 33
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/tlms_front.sv @@
// Front end: accepts script bytes, walks the template and stores the first key.
module tlms_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          script_byte,
    input  logic                last_byte,
    output logic                item_valid,
    input  logic                item_ready,
    output tlms_pkg::tlms_item_t item
);
    import tlms_pkg::*;

    localparam logic [KEY_ADDR_W-1:0] KEY_LAST = KEY_ADDR_W'(KEY_BYTES - 1);

    tlms_step_t              step_reg, step_next;
    logic [KEY_ADDR_W-1:0]   bif_reg, bif_next, bif_inc;
    logic [HLEN_W-1:0]       hlen_reg, hlen_next;
    logic [HEIGHT_W-1:0]     accum_reg, accum_next;
    logic                    failed_reg, failed_next;
    logic                    item_valid_reg;
    tlms_item_t              item_reg, item_d;
    logic                    accept, ok;
    logic                    key_write, key_read;
    logic [7:0]              stored_byte;

    assign full   = item_valid_reg && !item_ready;
    assign accept = push && !full;

    always_comb
    begin
        step_next   = step_reg;
        bif_next    = bif_reg;
        hlen_next   = hlen_reg;
        accum_next  = accum_reg;
        failed_next = failed_reg;
        bif_inc     = bif_reg + KEY_ADDR_W'(1);
        key_write   = 1'b0;
        key_read    = 1'b0;
        item_d      = '0;
        if (!failed_reg)
        begin
            case (step_reg)
                S_LEN:
                begin
                    if (script_byte < 8'd1 || script_byte > 8'(MAX_HEIGHT_BYTES))
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        hlen_next  = script_byte[HLEN_W-1:0];
                        accum_next = '0;
                        bif_next   = '0;
                        step_next  = S_HEIGHT;
                    end
                end
                S_HEIGHT:
                begin
                    accum_next = accum_reg |
                                 (HEIGHT_W'(script_byte) << {bif_reg[1:0], 3'b000});
                    if (bif_inc >= KEY_ADDR_W'(hlen_reg))
                    begin
                        bif_next  = '0;
                        step_next = S_CLTV;
                    end
                    else
                    begin
                        bif_next = bif_inc;
                    end
                end
                S_KEY1, S_KEY1_AGAIN, S_KEY2:
                begin
                    if (bif_reg > KEY_LAST)
                    begin
                        failed_next = 1'b1;
                    end
                    else
                    begin
                        item_d.key_byte  = script_byte;
                        item_d.key_which = (step_reg == S_KEY2) ? WHICH_SECOND : WHICH_FIRST;
                        item_d.key_index = 6'(bif_reg);
                        item_d.check_key = (step_reg == S_KEY1_AGAIN);
                        key_write        = (step_reg == S_KEY1);
                        key_read         = (step_reg == S_KEY1_AGAIN);
                        if (bif_reg == KEY_LAST)
                        begin
                            bif_next  = '0;
                            step_next = tlms_step_t'(step_reg + 5'd1);
                        end
                        else
                        begin
                            bif_next = bif_inc;
                        end
                    end
                end
                S_DONE:
                begin
                    failed_next = 1'b1;
                end
                default:
                begin
                    if (script_byte == want_op(step_reg))
                    begin
                        step_next = tlms_step_t'(step_reg + 5'd1);
                    end
                    else
                    begin
                        failed_next = 1'b1;
                    end
                end
            endcase
        end
        ok = !failed_next && (step_next == S_DONE) && (accum_reg != '0) &&
             (accum_reg < HEIGHT_LIMIT);
        if (last_byte)
        begin
            item_d.finished    = 1'b1;
            item_d.front_ok    = ok;
            item_d.lock_height = ok ? accum_reg[LOCK_W-1:0] : '0;
            step_next   = S_IF;
            bif_next    = '0;
            hlen_next   = '0;
            accum_next  = '0;
            failed_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= S_IF;
            bif_reg        <= '0;
            hlen_reg       <= '0;
            accum_reg      <= '0;
            failed_reg     <= 1'b0;
            item_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                step_reg   <= step_next;
                bif_reg    <= bif_next;
                hlen_reg   <= hlen_next;
                accum_reg  <= accum_next;
                failed_reg <= failed_next;
            end
            if (accept)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (item_ready)
            begin
                item_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_d;
        end
    end

    tlms_ram #(
        .WIDTH (8),
        .DEPTH (KEY_BYTES)
    ) u_key_store (
        .clk   (clk),
        .we    (accept && key_write),
        .waddr (bif_reg),
        .wdata (script_byte),
        .re    (accept && key_read),
        .raddr (bif_reg),
        .rdata (stored_byte)
    );

    always_comb
    begin
        item              = item_reg;
        item.key_mismatch = item_reg.check_key && (stored_byte != item_reg.key_byte);
    end

    assign item_valid = item_valid_reg;

    a_failed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        accept && failed_reg && !last_byte |=> failed_reg)
        else $error("failure flag cleared before the last byte");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_byte |=> step_reg == S_IF && !failed_reg && bif_reg == '0)
        else $error("template state not cleared after the last byte");

endmodule

@@ sv/tlms_fifo.sv @@
// Short queue of classified items between the front and back ends.
module tlms_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  tlms_pkg::tlms_item_t wr_item,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output tlms_pkg::tlms_item_t rd_item
);
    import tlms_pkg::*;

    tlms_item_t          entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wptr_reg, rptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    logic                do_wr, do_rd;

    assign wr_ready = count_reg < QCNT_W'(QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;
    assign rd_item  = entry_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wptr_reg <= (wptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rptr_reg <= (rptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wptr_reg] <= wr_item;
        end
    end

endmodule

@@ sv/tlms_back.sv @@
// Back end: applies the key repeat check, suppresses echoes after it fails, drives results.
module tlms_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  tlms_pkg::tlms_item_t          in_item,
    output logic                          empty,
    input  logic                          pop,
    output logic [7:0]                    key_byte,
    output logic [1:0]                    key_which,
    output logic [5:0]                    key_index,
    output logic                          finished,
    output logic                          status,
    output logic [tlms_pkg::LOCK_W-1:0]   lock_height
);
    import tlms_pkg::*;

    logic               out_valid_reg;
    logic               failed_reg, failed_next;
    logic               take, fail_now, ok;
    logic [7:0]         key_byte_reg, key_byte_next;
    logic [1:0]         key_which_reg, key_which_next;
    logic [5:0]         key_index_reg, key_index_next;
    logic               finished_reg, status_reg, status_next;
    logic [LOCK_W-1:0]  lock_reg, lock_next;

    assign in_ready = !out_valid_reg || pop;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        fail_now = failed_reg || in_item.key_mismatch;
        ok       = in_item.front_ok && !fail_now;
        if (failed_reg)
        begin
            key_byte_next  = '0;
            key_which_next = WHICH_NONE;
            key_index_next = '0;
        end
        else
        begin
            key_byte_next  = in_item.key_byte;
            key_which_next = in_item.key_which;
            key_index_next = in_item.key_index;
        end
        if (in_item.finished)
        begin
            status_next = ok ? STATUS_ACCEPT : STATUS_REJECT;
            lock_next   = ok ? in_item.lock_height : '0;
            failed_next = 1'b0;
        end
        else
        begin
            status_next = STATUS_ACCEPT;
            lock_next   = '0;
            failed_next = fail_now;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            failed_reg    <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                out_valid_reg <= 1'b1;
                failed_reg    <= failed_next;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            key_byte_reg  <= key_byte_next;
            key_which_reg <= key_which_next;
            key_index_reg <= key_index_next;
            finished_reg  <= in_item.finished;
            status_reg    <= status_next;
            lock_reg      <= lock_next;
        end
    end

    assign empty       = !out_valid_reg;
    assign key_byte    = key_byte_reg;
    assign key_which   = key_which_reg;
    assign key_index   = key_index_reg;
    assign finished    = finished_reg;
    assign status      = status_reg;
    assign lock_height = lock_reg;

    a_no_key_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && key_which_reg == WHICH_NONE |-> key_byte_reg == '0 && key_index_reg == '0)
        else $error("key fields set on a result without a key byte");

    a_unfinished_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !finished_reg |-> status_reg == STATUS_ACCEPT && lock_reg == '0)
        else $error("verdict fields set on an unfinished result");

    a_reject_no_height: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == STATUS_REJECT |-> lock_reg == '0)
        else $error("lock height reported on a rejected script");

    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> key_index_reg < 6'(KEY_BYTES))
        else $error("key index out of range");

endmodule

@@ sv/timelock_multisig_script_matcher.sv @@
// Top level of the time-locked two-party redeem script matcher.
//
//   channel   direction  transfer when     payload
//   input     in         push && !full     script_byte, last_byte
//   result    out        pop && !empty     key_byte, key_which, key_index, finished,
//                                          status, lock_height
//
// One script byte is taken per cycle while full is low, and each gives exactly one result
// on the result ports, after the front item register, the queue entry and the result
// register. The front end takes a byte every cycle unless full; the registered read of the
// 33-entry first key store lines up with the front item register for the key repeat
// check, and a two-entry queue decouples it from the result register.
// Reset clears all control state at once; the key store needs no clearing pass.
// A stalled result side fills the queue, after which full rises.
module timelock_multisig_script_matcher (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [7:0]                   script_byte,
    input  logic                         last_byte,
    output logic                         empty,
    input  logic                         pop,
    output logic [7:0]                   key_byte,
    output logic [1:0]                   key_which,
    output logic [5:0]                   key_index,
    output logic                         finished,
    output logic                         status,
    output logic [tlms_pkg::LOCK_W-1:0]  lock_height
);
    import tlms_pkg::*;

    tlms_item_t  front_item, queue_item;
    logic        front_valid, front_ready;
    logic        queue_valid, queue_ready;

    tlms_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .script_byte (script_byte),
        .last_byte   (last_byte),
        .item_valid  (front_valid),
        .item_ready  (front_ready),
        .item        (front_item)
    );

    tlms_fifo u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .wr_item  (front_item),
        .rd_valid (queue_valid),
        .rd_ready (queue_ready),
        .rd_item  (queue_item)
    );

    tlms_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (queue_valid),
        .in_ready    (queue_ready),
        .in_item     (queue_item),
        .empty       (empty),
        .pop         (pop),
        .key_byte    (key_byte),
        .key_which   (key_which),
        .key_index   (key_index),
        .finished    (finished),
        .status      (status),
        .lock_height (lock_height)
    );

endmodule

@@ tb/sv/tb_timelock_multisig_script_matcher.sv @@
// Testbench for the redeem script matcher: directed and random scripts checked against a predictor.
module tb_timelock_multisig_script_matcher;
    import tlms_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int HOLD_CYCLES  = 48;
    localparam int RANDOM_BYTES = 60;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [7:0]        key_byte;
        logic [1:0]        key_which;
        logic [5:0]        key_index;
        logic              finished;
        logic              status;
        logic [LOCK_W-1:0] lock_height;
    } script_result_t;

    typedef enum int {
        FAULT_NONE,
        FAULT_BYTE,
        FAULT_KEY_REPEAT,
        FAULT_TRUNCATE,
        FAULT_TRAILING,
        FAULT_LENGTH,
        FAULT_NOISE
    } fault_kind_t;

    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              push        = 1'b0;
    logic              pop         = 1'b0;
    logic [7:0]        script_byte = 8'h00;
    logic              last_byte   = 1'b0;
    logic              full;
    logic              empty;
    logic [7:0]        key_byte;
    logic [1:0]        key_which;
    logic [5:0]        key_index;
    logic              finished;
    logic              status;
    logic [LOCK_W-1:0] lock_height;

    tlms_step_t        tmpl_step   = S_IF;
    int                field_pos   = 0;
    int                height_len  = 0;
    logic [31:0]       height_acc  = '0;
    logic              script_failed = 1'b0;
    logic [7:0]        key1_copy [KEY_BYTES];

    script_result_t    pending_results [$];
    script_result_t    seen_result;
    script_result_t    want_result;
    logic [7:0]        script_buf [$];
    logic [7:0]        key_one [KEY_BYTES];
    logic [7:0]        key_two [KEY_BYTES];

    int                error_count   = 0;
    int                quiet_cycles  = 0;
    int                bytes_sent    = 0;
    logic              send_idle_on  = 1'b1;
    logic              recv_idle_on  = 1'b1;
    logic              hold_request  = 1'b0;

    timelock_multisig_script_matcher i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .script_byte (script_byte),
        .last_byte   (last_byte),
        .empty       (empty),
        .pop         (pop),
        .key_byte    (key_byte),
        .key_which   (key_which),
        .key_index   (key_index),
        .finished    (finished),
        .status      (status),
        .lock_height (lock_height)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic step_on_opcode(input logic [7:0] value, input logic [7:0] opcode);
        if (value == opcode)
        begin
            tmpl_step = tlms_step_t'(int'(tmpl_step) + 1);
        end
        else
        begin
            script_failed = 1'b1;
        end
    endtask

    task automatic match_script_byte(input logic [7:0] value, input logic is_last);
        script_result_t r;
        logic           ok;
        r = '0;
        if (!script_failed)
        begin
            case (tmpl_step)
                S_IF:       step_on_opcode(value, OP_IF);
                S_CLTV:     step_on_opcode(value, OP_CLTV);
                S_DROP:     step_on_opcode(value, OP_DROP);
                S_PUSH1:    step_on_opcode(value, OP_PUSH33);
                S_CHECKSIG: step_on_opcode(value, OP_CHECKSIG);
                S_ELSE:     step_on_opcode(value, OP_ELSE);
                S_TWO1:     step_on_opcode(value, OP_TWO);
                S_PUSHA:    step_on_opcode(value, OP_PUSH33);
                S_PUSHB:    step_on_opcode(value, OP_PUSH33);
                S_TWO2:     step_on_opcode(value, OP_TWO);
                S_CMS:      step_on_opcode(value, OP_CHECKMULTI);
                S_ENDIF:    step_on_opcode(value, OP_BRANCH_END);
                S_LEN:
                begin
                    if (value < 1 || value > MAX_HEIGHT_BYTES)
                    begin
                        script_failed = 1'b1;
                    end
                    else
                    begin
                        height_len = value;
                        height_acc = '0;
                        field_pos  = 0;
                        tmpl_step  = S_HEIGHT;
                    end
                end
                S_HEIGHT:
                begin
                    height_acc = height_acc | (32'(value) << (8 * (field_pos % 4)));
                    field_pos++;
                    if (field_pos >= height_len)
                    begin
                        field_pos = 0;
                        tmpl_step = S_CLTV;
                    end
                end
                S_KEY1, S_KEY1_AGAIN, S_KEY2:
                begin
                    if (field_pos >= KEY_BYTES)
                    begin
                        script_failed = 1'b1;
                    end
                    else
                    begin
                        r.key_byte  = value;
                        r.key_which = (tmpl_step == S_KEY2) ? WHICH_SECOND : WHICH_FIRST;
                        r.key_index = 6'(field_pos);
                        if (tmpl_step == S_KEY1)
                        begin
                            key1_copy[field_pos] = value;
                        end
                        else if (tmpl_step == S_KEY1_AGAIN && key1_copy[field_pos] != value)
                        begin
                            script_failed = 1'b1;
                        end
                        field_pos++;
                        if (field_pos >= KEY_BYTES)
                        begin
                            field_pos = 0;
                            tmpl_step = tlms_step_t'(int'(tmpl_step) + 1);
                        end
                    end
                end
                default:    script_failed = 1'b1;
            endcase
        end
        if (is_last)
        begin
            ok = !script_failed && tmpl_step == S_DONE && height_acc != 0
                 && height_acc < HEIGHT_LIMIT;
            r.finished    = 1'b1;
            r.status      = ok ? STATUS_ACCEPT : STATUS_REJECT;
            r.lock_height = ok ? height_acc[LOCK_W-1:0] : '0;
            tmpl_step     = S_IF;
            field_pos     = 0;
            height_len    = 0;
            height_acc    = '0;
            script_failed = 1'b0;
        end
        pending_results.push_back(r);
    endtask

    task automatic send_byte(input logic [7:0] value, input logic is_last);
        @(negedge clk);
        if (send_idle_on && $urandom_range(0, 7) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        push        <= 1'b1;
        script_byte <= value;
        last_byte   <= is_last;
        @(posedge clk);
        while (full) @(posedge clk);
        match_script_byte(value, is_last);
        bytes_sent++;
    endtask

    task automatic send_script();
        foreach (script_buf[i])
        begin
            send_byte(script_buf[i], i == script_buf.size() - 1);
        end
    endtask

    task automatic build_script(input int hlen, input logic [31:0] height);
        script_buf = {};
        script_buf.push_back(OP_IF);
        script_buf.push_back(8'(hlen));
        for (int i = 0; i < hlen; i++) script_buf.push_back(height[8*i +: 8]);
        script_buf.push_back(OP_CLTV);
        script_buf.push_back(OP_DROP);
        script_buf.push_back(OP_PUSH33);
        foreach (key_one[i]) script_buf.push_back(key_one[i]);
        script_buf.push_back(OP_CHECKSIG);
        script_buf.push_back(OP_ELSE);
        script_buf.push_back(OP_TWO);
        script_buf.push_back(OP_PUSH33);
        foreach (key_one[i]) script_buf.push_back(key_one[i]);
        script_buf.push_back(OP_PUSH33);
        foreach (key_two[i]) script_buf.push_back(key_two[i]);
        script_buf.push_back(OP_TWO);
        script_buf.push_back(OP_CHECKMULTI);
        script_buf.push_back(OP_BRANCH_END);
    endtask

    task automatic build_random_script(output int hlen);
        logic [31:0] mask;
        logic [31:0] height;
        foreach (key_one[i]) key_one[i] = 8'($urandom());
        foreach (key_two[i]) key_two[i] = 8'($urandom());
        hlen = $urandom_range(1, MAX_HEIGHT_BYTES);
        mask = (hlen == 4) ? 32'hffff_ffff : ((32'd1 << (8 * hlen)) - 1);
        case ($urandom_range(0, 7))
            0:       height = '0;
            1:       height = (hlen == 4) ? $urandom_range(HEIGHT_LIMIT, 32'hffff_ffff) : mask;
            default: height = (hlen == 4) ? $urandom_range(1, HEIGHT_LIMIT - 1)
                                          : ($urandom() & mask);
        endcase
        build_script(hlen, height);
    endtask

    task automatic test_accepted_scripts();
        foreach (key_one[i]) key_one[i] = (i % 2 == 0) ? 8'h00 : 8'hff;
        foreach (key_two[i]) key_two[i] = (i % 2 == 0) ? 8'hff : 8'h00;
        build_script(4, HEIGHT_LIMIT - 1);
        send_script();
        foreach (key_two[i]) key_two[i] = 8'(i * 37 + 5);
        build_script(1, 32'd1);
        send_script();
    endtask

    task automatic test_rejected_heights();
        build_script(4, HEIGHT_LIMIT);
        send_script();
        build_script(2, 32'd0);
        send_script();
        script_buf = '{OP_IF, 8'h00, OP_CLTV};
        send_script();
        script_buf = '{OP_IF, 8'h05, 8'h01};
        send_script();
        script_buf = '{OP_IF, 8'hff};
        send_script();
    endtask

    task automatic test_template_faults();
        build_script(2, 32'd700);
        script_buf[2 + 42 + 3] = ~script_buf[2 + 42 + 3];
        send_script();
        script_buf = '{OP_IF};
        send_script();
        script_buf = '{8'hff, OP_IF, 8'h01};
        send_script();
        script_buf = '{OP_IF, 8'h01, 8'h05, 8'hb2, OP_DROP};
        send_script();
    endtask

    task automatic test_backpressure();
        int hlen;
        send_idle_on = 1'b0;
        hold_request = 1'b1;
        build_random_script(hlen);
        send_script();
        send_idle_on = 1'b1;
    endtask

    task automatic test_random_scripts();
        int          hlen;
        int          target;
        int          cut;
        fault_kind_t fault;
        target = bytes_sent + RANDOM_BYTES;
        while (bytes_sent < target)
        begin
            send_idle_on = ($urandom_range(0, 3) != 0);
            recv_idle_on = ($urandom_range(0, 3) != 0);
            build_random_script(hlen);
            case ($urandom_range(0, 19))
                11, 12:  fault = FAULT_BYTE;
                13:      fault = FAULT_KEY_REPEAT;
                14, 15:  fault = FAULT_TRUNCATE;
                16:      fault = FAULT_TRAILING;
                17:      fault = FAULT_LENGTH;
                18, 19:  fault = FAULT_NOISE;
                default: fault = FAULT_NONE;
            endcase
            case (fault)
                FAULT_BYTE:
                begin
                    cut = $urandom_range(0, script_buf.size() - 1);
                    script_buf[cut] = script_buf[cut] ^ 8'($urandom_range(1, 255));
                end
                FAULT_KEY_REPEAT:
                begin
                    cut = hlen + 42 + $urandom_range(0, KEY_BYTES - 1);
                    script_buf[cut] = script_buf[cut] ^ 8'($urandom_range(1, 255));
                end
                FAULT_TRUNCATE:
                begin
                    cut = $urandom_range(1, script_buf.size() - 1);
                    while (script_buf.size() > cut) void'(script_buf.pop_back());
                end
                FAULT_TRAILING:
                begin
                    repeat ($urandom_range(1, 3)) script_buf.push_back(8'($urandom()));
                end
                FAULT_LENGTH:
                begin
                    script_buf[1] = ($urandom_range(0, 1) == 0) ? 8'h00
                                    : 8'($urandom_range(MAX_HEIGHT_BYTES + 1, 255));
                end
                FAULT_NOISE:
                begin
                    script_buf = {};
                    repeat ($urandom_range(1, 8)) script_buf.push_back(8'($urandom()));
                end
                default:
                begin
                end
            endcase
            send_script();
        end
    endtask

    task automatic test_quiet_tail();
        int hlen;
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        build_random_script(hlen);
        send_script();
    endtask

    initial
    begin : result_sink
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
                pop <= 1'b1;
            end
            else if (recv_idle_on && $urandom_range(0, 7) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge clk);
                pop <= 1'b1;
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            seen_result = {key_byte, key_which, key_index, finished, status, lock_height};
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                begin
                    $display("unexpected result transfer: key_byte=%0h key_which=%0d",
                             key_byte, key_which);
                end
            end
            else
            begin
                want_result = pending_results.pop_front();
                if (seen_result !== want_result)
                begin
                    error_count++;
                    if (error_count <= 10)
                    begin
                        $display("mismatch: expected byte=%0h which=%0d index=%0d fin=%0b st=%0b h=%0d",
                                 want_result.key_byte, want_result.key_which,
                                 want_result.key_index, want_result.finished,
                                 want_result.status, want_result.lock_height);
                        $display("          actual   byte=%0h which=%0d index=%0d fin=%0b st=%0b h=%0d",
                                 key_byte, key_which, key_index, finished, status, lock_height);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        foreach (key1_copy[i]) key1_copy[i] = 8'h00;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        test_accepted_scripts();
        test_rejected_heights();
        test_template_faults();
        test_backpressure();
        test_random_scripts();
        test_quiet_tail();
        @(negedge clk);
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
